>>> hw/rtl/sip_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sip_pkg - shared types and constants for the soft interrupt register block
// Request kinds, register select codes, request beat and result layouts.
// -----------------------------------------------------------------------------
package sip_pkg;

   typedef enum logic [1:0] {
      KIND_WRITE = 2'd0,
      KIND_READ  = 2'd1,
      KIND_TICK  = 2'd2
   } kind_type;

   localparam logic [3:0] SEL_SOFTINT = 4'd0;
   localparam logic [3:0] SEL_CLR     = 4'd1;
   localparam logic [3:0] SEL_SET     = 4'd2;
   localparam logic [3:0] SEL_LEVEL   = 4'd3;
   localparam logic [3:0] SEL_HV      = 4'd4;
   localparam logic [3:0] SEL_TBA     = 4'd5;
   localparam logic [3:0] SEL_Q_FIRST = 4'd6;
   localparam logic [3:0] SEL_Q_LAST  = 4'd13;
   localparam logic [3:0] SEL_CMP     = 4'd14;
   localparam logic [3:0] SEL_HV_CMP  = 4'd15;

   localparam int          SOFT_W     = 17;
   localparam int          TICK_W     = 63;
   localparam int          QUEUES     = 8;
   localparam logic [3:0]  LEVEL_HI   = 4'd14;
   localparam logic [63:0] CMP_RESET  = 64'h8000_0000_0000_0000;
   localparam logic [63:0] TBA_KEEP   = ~64'h7FFF;
   localparam logic [16:0] TICK_SOFT  = 17'h10000;
   localparam logic [16:0] EDGE_BITS  = 17'h10001;

   typedef struct packed {
      kind_type    kind;
      logic [3:0]  sel;
      logic [63:0] wdata;
   } req_beat_type;

   typedef struct packed {
      logic              res_error_irq;
      logic              dev_mondo_irq;
      logic              cpu_mondo_irq;
      logic              hv_irq;
      logic [SOFT_W-1:0] soft_pending;
      logic [63:0]       rdata;
   } result_type;

endpackage
`default_nettype wire

>>> hw/rtl/sip_regfile.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// sip_regfile - interrupt register state and single-pass update
// Applies one request beat per step and forms the result from the new state.
// -----------------------------------------------------------------------------
module sip_regfile (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  step,
   input  wire sip_pkg::req_beat_type req,
   output sip_pkg::result_type        res
);

   logic [sip_pkg::SOFT_W-1:0] soft_bits_ff, soft_bits_in;
   logic [3:0]                 int_level_ff, int_level_in;
   logic                       hv_pending_ff, hv_pending_in;
   logic [63:0]                trap_base_ff, trap_base_in;
   logic [63:0]                queue_ptrs_ff [sip_pkg::QUEUES];
   logic [63:0]                queue_ptrs_in [sip_pkg::QUEUES];
   logic [sip_pkg::TICK_W-1:0] sys_tick_ff, sys_tick_in;
   logic [63:0]                tick_cmp_ff, tick_cmp_in;
   logic [63:0]                hv_cmp_ff, hv_cmp_in;
   logic [2:0]                 q_idx;
   logic [63:0]                rdata;

   function automatic logic [sip_pkg::SOFT_W-1:0] pending_vec(
      input logic [sip_pkg::SOFT_W-1:0] bits,
      input logic [3:0]                 level
   );
      logic [sip_pkg::SOFT_W-1:0] p;
      p = '0;
      if (level < sip_pkg::LEVEL_HI) begin
         p = bits & sip_pkg::EDGE_BITS;
      end
      for (int n = 1; n < 16; n++) begin
         if (bits[n] && (4'(n) > level)) begin
            p[n] = 1'b1;
         end
      end
      return p;
   endfunction

   assign q_idx = 3'(req.sel - sip_pkg::SEL_Q_FIRST);

   always_comb begin
      soft_bits_in  = soft_bits_ff;
      int_level_in  = int_level_ff;
      hv_pending_in = hv_pending_ff;
      trap_base_in  = trap_base_ff;
      queue_ptrs_in = queue_ptrs_ff;
      sys_tick_in   = sys_tick_ff;
      tick_cmp_in   = tick_cmp_ff;
      hv_cmp_in     = hv_cmp_ff;
      rdata         = '0;
      case (req.kind)
         sip_pkg::KIND_WRITE: begin
            case (req.sel) inside
               sip_pkg::SEL_SOFTINT: soft_bits_in  = req.wdata[sip_pkg::SOFT_W-1:0];
               sip_pkg::SEL_CLR:     soft_bits_in  = soft_bits_ff
                                                     & ~req.wdata[sip_pkg::SOFT_W-1:0];
               sip_pkg::SEL_SET:     soft_bits_in  = soft_bits_ff
                                                     | req.wdata[sip_pkg::SOFT_W-1:0];
               sip_pkg::SEL_LEVEL:   int_level_in  = req.wdata[3:0];
               sip_pkg::SEL_HV:      hv_pending_in = req.wdata[0];
               sip_pkg::SEL_TBA:     trap_base_in  = req.wdata & sip_pkg::TBA_KEEP;
               [sip_pkg::SEL_Q_FIRST:sip_pkg::SEL_Q_LAST]:
                                     queue_ptrs_in[q_idx] = req.wdata;
               sip_pkg::SEL_CMP:     tick_cmp_in   = req.wdata;
               default:              hv_cmp_in     = req.wdata;
            endcase
         end
         sip_pkg::KIND_READ: begin
            case (req.sel) inside
               sip_pkg::SEL_SOFTINT: rdata = 64'(soft_bits_ff);
               sip_pkg::SEL_LEVEL:   rdata = 64'(int_level_ff);
               sip_pkg::SEL_HV:      rdata = 64'(hv_pending_ff);
               sip_pkg::SEL_TBA:     rdata = trap_base_ff & sip_pkg::TBA_KEEP;
               [sip_pkg::SEL_Q_FIRST:sip_pkg::SEL_Q_LAST]:
                                     rdata = queue_ptrs_ff[q_idx];
               sip_pkg::SEL_CMP:     rdata = tick_cmp_ff;
               sip_pkg::SEL_HV_CMP:  rdata = hv_cmp_ff;
               default:              rdata = '0;   // set/clear aliases read zero
            endcase
         end
         sip_pkg::KIND_TICK: begin
            sys_tick_in = sys_tick_ff + 1'b1;
            // bit 63 of a compare disables it
            if (!tick_cmp_ff[63] && (tick_cmp_ff[62:0] == sys_tick_in)) begin
               soft_bits_in = soft_bits_ff | sip_pkg::TICK_SOFT;
            end
            if (!hv_cmp_ff[63] && (hv_cmp_ff[62:0] == sys_tick_in)) begin
               hv_pending_in = 1'b1;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         soft_bits_ff  <= '0;
         int_level_ff  <= '0;
         hv_pending_ff <= 1'b0;
         trap_base_ff  <= '0;
         for (int i = 0; i < sip_pkg::QUEUES; i++) begin
            queue_ptrs_ff[i] <= '0;
         end
         sys_tick_ff   <= '0;
         tick_cmp_ff   <= sip_pkg::CMP_RESET;
         hv_cmp_ff     <= sip_pkg::CMP_RESET;
      end else if (step) begin
         soft_bits_ff  <= soft_bits_in;
         int_level_ff  <= int_level_in;
         hv_pending_ff <= hv_pending_in;
         trap_base_ff  <= trap_base_in;
         queue_ptrs_ff <= queue_ptrs_in;
         sys_tick_ff   <= sys_tick_in;
         tick_cmp_ff   <= tick_cmp_in;
         hv_cmp_ff     <= hv_cmp_in;
      end
   end

   // result reflects the state after this beat
   always_comb begin
      res.rdata         = rdata;
      res.soft_pending  = pending_vec(soft_bits_in, int_level_in);
      res.hv_irq        = hv_pending_in;
      res.cpu_mondo_irq = queue_ptrs_in[0] != queue_ptrs_in[1];
      res.dev_mondo_irq = queue_ptrs_in[2] != queue_ptrs_in[3];
      res.res_error_irq = queue_ptrs_in[4] != queue_ptrs_in[5];
   end

   a_tba_aligned: assert property (@(posedge clock) disable iff (reset)
      trap_base_ff[14:0] == '0)
      else $error("trap base low bits not clear");

   a_pending_subset: assert property (@(posedge clock) disable iff (reset)
      (res.soft_pending & ~soft_bits_in) == '0)
      else $error("pending bit without soft bit");

   a_tick_advance: assert property (@(posedge clock) disable iff (reset)
      step && (req.kind == sip_pkg::KIND_TICK)
      |=> sys_tick_ff == sip_pkg::TICK_W'($past(sys_tick_ff) + 1'b1))
      else $error("tick did not advance counter");

   a_tick_hold: assert property (@(posedge clock) disable iff (reset)
      !(step && (req.kind == sip_pkg::KIND_TICK)) |=> $stable(sys_tick_ff))
      else $error("counter moved without tick");

endmodule
`default_nettype wire

>>> hw/rtl/softint_pil_interrupt_regs_top.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// softint_pil_interrupt_regs_top - soft interrupt / level / queue register block
// Stream front end around the interrupt register file.
// -----------------------------------------------------------------------------
// Usage:
//   req_* carries one request beat: a register write, a register read or one
//   system tick (kind and register select in req_tuser, write data in
//   req_tdata). Every accepted beat yields exactly one rsp_* beat holding the
//   read data (zero unless a read) and the interrupt lines as they stand after
//   the beat has been applied.
//   Path: a beat is captured in the input stage, applied to the register
//   file as it leaves that stage, and the result is registered in the output
//   register, which drives rsp_tvalid; while the output register is full the
//   beat waits in the input stage until the output drains.
//   Throughput: one beat per cycle while rsp_tready is high; the update is
//   one shallow compare-and-mask pass between input stage and output register.
//   Stall: while rsp_tready is low the output register holds its beat and the
//   input stage can still take one more request; req_tready then drops until
//   the output drains.
//   Reset: synchronous; both stages empty, soft bits, level, hypervisor bit,
//   trap base, queue pointers and tick counter zero, both compares disabled
//   (bit 63 set).
// -----------------------------------------------------------------------------
module softint_pil_interrupt_regs_top (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [63:0] req_tdata,   // [63:0] wdata
   input  wire logic [5:0]  req_tuser,   // [1:0] req_type, [5:2] reg_sel
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   // [63:0] rdata, [80:64] soft_pending, [81] hv_irq, [82] cpu_mondo_irq,
   // [83] dev_mondo_irq, [84] res_error_irq, [87:85] zero
   output logic [87:0]      rsp_tdata
);

   logic                  in_valid_ff, in_valid_in;
   sip_pkg::req_beat_type in_beat_ff;
   logic                  out_valid_ff, out_valid_in;
   sip_pkg::result_type   out_ff;
   sip_pkg::result_type   res;
   logic                  advance;
   logic                  req_take;

   // input stage moves on when the output register is free or draining
   assign advance     = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready  = !in_valid_ff || advance;
   assign req_take    = req_tvalid && req_tready;

   assign in_valid_in  = req_take || (in_valid_ff && !advance);
   assign out_valid_in = advance || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_beat_ff.kind  <= sip_pkg::kind_type'(req_tuser[1:0]);
         in_beat_ff.sel   <= req_tuser[5:2];
         in_beat_ff.wdata <= req_tdata;
      end
      if (advance) begin
         out_ff <= res;
      end
   end

   sip_regfile u_regfile (
      .clock (clock),
      .reset (reset),
      .step  (advance),
      .req   (in_beat_ff),
      .res   (res)
   );

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {3'b000, out_ff.res_error_irq, out_ff.dev_mondo_irq,
                        out_ff.cpu_mondo_irq, out_ff.hv_irq, out_ff.soft_pending,
                        out_ff.rdata};

   a_rdata_zero: assert property (@(posedge clock) disable iff (reset)
      advance && (in_beat_ff.kind != sip_pkg::KIND_READ) |=> out_ff.rdata == '0)
      else $error("nonzero read data on non-read beat");

   a_out_loaded: assert property (@(posedge clock) disable iff (reset)
      advance |=> out_valid_ff)
      else $error("applied beat produced no result");

   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && out_valid_ff && !rsp_tready |-> !req_tready)
      else $error("input stage overrun while output stalled");

endmodule
`default_nettype wire
